FILE: rtl/core/trlls_pkg.sv
// ----------------------------------------------------------------------------
// trlls_pkg
// Shared types, widths and saturating helpers for the two-response
// least-squares fitter.
// ----------------------------------------------------------------------------
package trlls_pkg;

  localparam int MAX_SAMPLES_DEF = 32;
  localparam int DATA_W  = 16;
  localparam int WORD_W  = 48;
  localparam int SUM_W   = 22;
  localparam int PSUM_W  = 38;
  localparam int OPA_W   = 64;
  localparam int OPB_W   = 48;
  localparam int LOW_W   = 80;
  localparam int TOP_W   = 49;
  localparam int MAG_W   = 81;
  localparam int MUL_CYC = 48;
  localparam int DIV_CYC = 80;

  localparam logic signed [WORD_W-1:0] WMAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [WORD_W-1:0] WMIN = 48'sh8000_0000_0000;
  localparam logic [MAG_W-1:0] MAG_POS_MAX = 81'h7FFF_FFFF_FFFF;
  localparam logic [MAG_W-1:0] MAG_NEG_MAX = 81'h8000_0000_0000;

  typedef enum logic [1:0] {
    KIND_COEF = 2'd0,
    KIND_ROW  = 2'd1,
    KIND_SUMS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SINGULAR = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_READ,
    S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    ST_NSXX,
    ST_SXSX,
    ST_R0_P,
    ST_R0_Q,
    ST_R0_DIV,
    ST_R1_P,
    ST_R1_Q,
    ST_R1_DIV,
    ST_FIT1,
    ST_FIT2,
    ST_ACC0,
    ST_ACC1,
    ST_ACC2,
    ST_ACC3,
    ST_ACC4,
    ST_ACC5
  } step_t;

  typedef enum logic [1:0] {
    EM_SING,
    EM_COEF,
    EM_ROW,
    EM_SUMS
  } emit_t;

  typedef struct packed {
    logic                    start;
    logic                    is_div;
    logic signed [OPA_W-1:0] a;
    logic signed [OPB_W-1:0] b;
    logic [4:0]              shift;
  } au_req_t;

  typedef struct packed {
    logic             done;
    logic             neg;
    logic             round_up;
    logic [TOP_W-1:0] top;
    logic [LOW_W-1:0] low;
  } au_rsp_t;

  // Signed saturation of a magnitude with a separate sign.
  function automatic logic signed [WORD_W-1:0] sat_mag(input logic [MAG_W-1:0] m,
                                                       input logic neg);
    logic signed [WORD_W-1:0] r;
    if (neg) begin
      if (m > MAG_NEG_MAX) r = WMIN;
      else r = $signed(~m[WORD_W-1:0] + 48'd1);
    end else begin
      if (m > MAG_POS_MAX) r = WMAX;
      else r = $signed(m[WORD_W-1:0]);
    end
    return r;
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_add(input logic signed [WORD_W-1:0] a,
                                                       input logic signed [WORD_W-1:0] b);
    logic signed [WORD_W:0] s;
    logic signed [WORD_W-1:0] r;
    s = 49'(a) + 49'(b);
    if (s[WORD_W] != s[WORD_W-1]) r = s[WORD_W] ? WMIN : WMAX;
    else r = s[WORD_W-1:0];
    return r;
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_sub(input logic signed [WORD_W-1:0] a,
                                                       input logic signed [WORD_W-1:0] b);
    logic signed [WORD_W:0] s;
    logic signed [WORD_W-1:0] r;
    s = 49'(a) - 49'(b);
    if (s[WORD_W] != s[WORD_W-1]) r = s[WORD_W] ? WMIN : WMAX;
    else r = s[WORD_W-1:0];
    return r;
  endfunction

endpackage

FILE: rtl/core/trlls_ram.sv
// ----------------------------------------------------------------------------
// trlls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trlls_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/trlls_arith.sv
// ----------------------------------------------------------------------------
// trlls_arith
// Shared sign-magnitude unit: shift-add multiply (one multiplier bit a cycle)
// or restoring divide (one quotient bit a cycle).
// ----------------------------------------------------------------------------
module trlls_arith (
  input  logic                clk,
  input  logic                rst_n,
  input  trlls_pkg::au_req_t  req,
  output trlls_pkg::au_rsp_t  rsp
);

  logic                                busy_r;
  logic                                done_r;
  logic [6:0]                          cnt_r;
  logic [trlls_pkg::TOP_W-1:0]         top_r;
  logic [trlls_pkg::LOW_W-1:0]         low_r;
  logic [trlls_pkg::OPB_W-1:0]         md_r;
  logic                                neg_r;
  logic                                div_r;

  logic [trlls_pkg::OPA_W-1:0]         a_mag;
  logic [trlls_pkg::OPB_W-1:0]         b_mag;
  logic [trlls_pkg::TOP_W-1:0]         mul_sum;
  logic [trlls_pkg::TOP_W-1:0]         div_r2;
  logic [trlls_pkg::TOP_W-1:0]         div_diff;
  logic                                div_ge;

  assign a_mag = req.a[trlls_pkg::OPA_W-1] ? (~req.a + 64'd1) : req.a;
  assign b_mag = req.b[trlls_pkg::OPB_W-1] ? (~req.b + 48'd1) : req.b;

  assign mul_sum  = {1'b0, top_r[47:0]} + (low_r[0] ? {1'b0, md_r} : 49'd0);
  assign div_r2   = {top_r[47:0], low_r[trlls_pkg::LOW_W-1]};
  assign div_ge   = div_r2 >= {1'b0, md_r};
  assign div_diff = div_r2 - {1'b0, md_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= busy_r && (cnt_r == 7'd1);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.is_div ? 7'(trlls_pkg::DIV_CYC) : 7'(trlls_pkg::MUL_CYC);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.a[trlls_pkg::OPA_W-1] ^ req.b[trlls_pkg::OPB_W-1];
      div_r <= req.is_div;
      top_r <= '0;
      if (req.is_div) begin
        md_r  <= b_mag;
        low_r <= 80'(a_mag) << req.shift;
      end else begin
        md_r  <= a_mag[trlls_pkg::OPB_W-1:0];
        low_r <= {32'd0, b_mag};
      end
    end else if (busy_r) begin
      if (div_r) begin
        top_r <= div_ge ? div_diff : div_r2;
        low_r <= {low_r[trlls_pkg::LOW_W-2:0], div_ge};
      end else begin
        // Product high half shifts right; its low bit drops into the low half.
        top_r <= {1'b0, mul_sum[trlls_pkg::TOP_W-1:1]};
        low_r <= {32'd0, mul_sum[0], low_r[47:1]};
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.neg      = neg_r;
  assign rsp.round_up = {top_r[47:0], 1'b0} >= {1'b0, md_r};
  assign rsp.top      = top_r;
  assign rsp.low      = low_r;

endmodule

FILE: rtl/core/trlls_ctrl.sv
// ----------------------------------------------------------------------------
// trlls_ctrl
// Sample loading, running sums and the solve/replay sequencer that drives
// the shared arithmetic unit and the result register.
// ----------------------------------------------------------------------------
module trlls_ctrl #(
  parameter int MAX_SAMPLES = trlls_pkg::MAX_SAMPLES_DEF,
  parameter int AW          = $clog2(MAX_SAMPLES)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [15:0]       in_predictor,
  input  logic signed [15:0]       in_response_one,
  input  logic signed [15:0]       in_response_two,
  input  logic                     in_final_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_kind,
  output logic [1:0]               out_status,
  output logic signed [47:0]       out_word_a,
  output logic signed [47:0]       out_word_b,
  output logic signed [47:0]       out_word_c,
  output logic signed [47:0]       out_word_d,
  output logic signed [47:0]       out_word_e,
  output logic signed [47:0]       out_word_f,
  output logic                     out_run_end,
  output logic                     ram_we,
  output logic [AW-1:0]            ram_waddr,
  output logic [47:0]              ram_wdata,
  output logic                     ram_re,
  output logic [AW-1:0]            ram_raddr,
  input  logic [47:0]              ram_rdata,
  output trlls_pkg::au_req_t       au_req,
  input  trlls_pkg::au_rsp_t       au_rsp
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  trlls_pkg::state_t state_r, state_nxt;
  trlls_pkg::step_t  step_r, step_nxt;
  trlls_pkg::emit_t  emit_r, emit_nxt;
  logic              resp_r, resp_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;

  logic [CW-1:0]                        count_r;
  logic                                 ovf_r;
  logic signed [trlls_pkg::SUM_W-1:0]   sx_r, sy1_r, sy2_r;
  logic signed [trlls_pkg::PSUM_W-1:0]  sxx_r, sxy1_r, sxy2_r;

  logic signed [63:0] t0_r, num_r;
  logic signed [47:0] det_r;
  logic signed [47:0] c0a_r, c1a_r, c0b_r, c1b_r;
  logic signed [47:0] f1_r, f2_r, r1_r, r2_r;
  logic signed [47:0] acc_r [6];

  logic               out_valid_r;
  trlls_pkg::kind_t   out_kind_r;
  trlls_pkg::status_t out_status_r;
  logic signed [47:0] out_a_r, out_b_r, out_c_r, out_d_r, out_e_r, out_f_r;
  logic               out_end_r;

  logic               accept, has_room, out_free, emit_go, cap;
  logic signed [31:0] p_xx, p_xy1, p_xy2;
  logic signed [47:0] n_w, sy_sel, sxy_sel, sx_w, sxx_w;
  logic signed [15:0] rx, ry1, ry2;
  logic signed [47:0] xq, y1q, y2q;
  logic [95:0]        prod;
  logic signed [63:0] pv, diff;
  logic [96:0]        rnd;
  logic signed [47:0] mq, dq, fit;
  logic [2:0]         acc_idx;
  trlls_pkg::status_t run_status;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == trlls_pkg::S_IDLE);
  assign has_room = count_r < CW'(MAX_SAMPLES);
  assign out_free = !out_valid_r || out_ready;
  assign emit_go  = (state_r == trlls_pkg::S_EMIT) && out_free;
  assign cap      = (state_r == trlls_pkg::S_WAIT) && au_rsp.done;

  assign p_xx  = in_predictor * in_predictor;
  assign p_xy1 = in_predictor * in_response_one;
  assign p_xy2 = in_predictor * in_response_two;

  assign ram_we    = accept && has_room;
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = {in_predictor, in_response_one, in_response_two};
  assign ram_re    = (state_r == trlls_pkg::S_READ);
  assign ram_raddr = idx_r[AW-1:0];

  assign n_w     = $signed(48'(count_r));
  assign sx_w    = 48'(sx_r);
  assign sxx_w   = 48'(sxx_r);
  assign sy_sel  = resp_r ? 48'(sy2_r) : 48'(sy1_r);
  assign sxy_sel = resp_r ? 48'(sxy2_r) : 48'(sxy1_r);

  assign rx  = $signed(ram_rdata[47:32]);
  assign ry1 = $signed(ram_rdata[31:16]);
  assign ry2 = $signed(ram_rdata[15:0]);
  assign xq  = $signed({{24{rx[15]}}, rx, 8'd0});
  assign y1q = $signed({{24{ry1[15]}}, ry1, 8'd0});
  assign y2q = $signed({{24{ry2[15]}}, ry2, 8'd0});

  // Exact signed product for the solve, rounded Q31.16 product for the replay.
  assign prod = {au_rsp.top[47:0], au_rsp.low[47:0]};
  assign pv   = au_rsp.neg ? $signed(~prod[63:0] + 64'd1) : $signed(prod[63:0]);
  assign diff = t0_r - pv;
  assign rnd  = 97'(prod) + 97'h8000;
  assign mq   = trlls_pkg::sat_mag(rnd[96:16], au_rsp.neg);
  assign dq   = trlls_pkg::sat_mag(81'(au_rsp.low) + 81'(au_rsp.round_up), au_rsp.neg);
  assign fit  = trlls_pkg::sat_add((step_r == trlls_pkg::ST_FIT1) ? c0a_r : c0b_r, mq);
  assign acc_idx = 3'(step_r - trlls_pkg::ST_ACC0);
  assign run_status = ovf_r ? trlls_pkg::STATUS_OVERFLOW : trlls_pkg::STATUS_OK;

  always_comb begin
    au_req.start  = (state_r == trlls_pkg::S_ISSUE);
    au_req.is_div = 1'b0;
    au_req.a      = '0;
    au_req.b      = '0;
    au_req.shift  = 5'd0;
    case (step_r)
      trlls_pkg::ST_NSXX: begin
        au_req.a = 64'(n_w);  au_req.b = sxx_w;
      end
      trlls_pkg::ST_SXSX: begin
        au_req.a = 64'(sx_w); au_req.b = sx_w;
      end
      trlls_pkg::ST_R0_P: begin
        au_req.a = 64'(sxx_w); au_req.b = sy_sel;
      end
      trlls_pkg::ST_R0_Q: begin
        au_req.a = 64'(sx_w); au_req.b = sxy_sel;
      end
      trlls_pkg::ST_R1_P: begin
        au_req.a = 64'(n_w);  au_req.b = sxy_sel;
      end
      trlls_pkg::ST_R1_Q: begin
        au_req.a = 64'(sx_w); au_req.b = sy_sel;
      end
      trlls_pkg::ST_R0_DIV: begin
        au_req.is_div = 1'b1; au_req.a = num_r; au_req.b = det_r; au_req.shift = 5'd8;
      end
      trlls_pkg::ST_R1_DIV: begin
        au_req.is_div = 1'b1; au_req.a = num_r; au_req.b = det_r; au_req.shift = 5'd16;
      end
      trlls_pkg::ST_FIT1: begin
        au_req.a = 64'(c1a_r); au_req.b = xq;
      end
      trlls_pkg::ST_FIT2: begin
        au_req.a = 64'(c1b_r); au_req.b = xq;
      end
      trlls_pkg::ST_ACC0: begin
        au_req.a = 64'(f1_r); au_req.b = f1_r;
      end
      trlls_pkg::ST_ACC1: begin
        au_req.a = 64'(f2_r); au_req.b = f2_r;
      end
      trlls_pkg::ST_ACC2: begin
        au_req.a = 64'(f1_r); au_req.b = f2_r;
      end
      trlls_pkg::ST_ACC3: begin
        au_req.a = 64'(r1_r); au_req.b = r1_r;
      end
      trlls_pkg::ST_ACC4: begin
        au_req.a = 64'(r2_r); au_req.b = r2_r;
      end
      trlls_pkg::ST_ACC5: begin
        au_req.a = 64'(r1_r); au_req.b = r2_r;
      end
      default: begin
        au_req.a = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    emit_nxt  = emit_r;
    resp_nxt  = resp_r;
    idx_nxt   = idx_r;
    case (state_r)
      trlls_pkg::S_IDLE: begin
        if (accept && in_final_sample) begin
          state_nxt = trlls_pkg::S_ISSUE;
          step_nxt  = trlls_pkg::ST_NSXX;
          resp_nxt  = 1'b0;
        end
      end
      trlls_pkg::S_ISSUE: begin
        state_nxt = trlls_pkg::S_WAIT;
      end
      trlls_pkg::S_WAIT: begin
        if (au_rsp.done) begin
          state_nxt = trlls_pkg::S_ISSUE;
          case (step_r)
            trlls_pkg::ST_SXSX: begin
              if (diff == 64'sd0) begin
                state_nxt = trlls_pkg::S_EMIT;
                emit_nxt  = trlls_pkg::EM_SING;
              end else begin
                step_nxt = trlls_pkg::ST_R0_P;
              end
            end
            trlls_pkg::ST_R1_DIV: begin
              if (!resp_r) begin
                resp_nxt = 1'b1;
                step_nxt = trlls_pkg::ST_R0_P;
              end else begin
                state_nxt = trlls_pkg::S_EMIT;
                emit_nxt  = trlls_pkg::EM_COEF;
              end
            end
            trlls_pkg::ST_FIT2: begin
              state_nxt = trlls_pkg::S_EMIT;
              emit_nxt  = trlls_pkg::EM_ROW;
            end
            trlls_pkg::ST_ACC5: begin
              if (idx_r + CW'(1) == count_r) begin
                state_nxt = trlls_pkg::S_EMIT;
                emit_nxt  = trlls_pkg::EM_SUMS;
              end else begin
                idx_nxt   = idx_r + CW'(1);
                state_nxt = trlls_pkg::S_READ;
              end
            end
            default: begin
              step_nxt = trlls_pkg::step_t'(step_r + 4'd1);
            end
          endcase
        end
      end
      trlls_pkg::S_READ: begin
        state_nxt = trlls_pkg::S_ISSUE;
        step_nxt  = trlls_pkg::ST_FIT1;
      end
      trlls_pkg::S_EMIT: begin
        if (out_free) begin
          case (emit_r)
            trlls_pkg::EM_COEF: begin
              idx_nxt   = '0;
              state_nxt = trlls_pkg::S_READ;
            end
            trlls_pkg::EM_ROW: begin
              step_nxt  = trlls_pkg::ST_ACC0;
              state_nxt = trlls_pkg::S_ISSUE;
            end
            default: begin
              state_nxt = trlls_pkg::S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = trlls_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trlls_pkg::S_IDLE;
      step_r  <= trlls_pkg::ST_NSXX;
      emit_r  <= trlls_pkg::EM_SING;
      resp_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      emit_r  <= emit_nxt;
      resp_r  <= resp_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Run sums; cleared once the last word of a run is loaded for output.
  always_ff @(posedge clk) begin
    if (!rst_n || (emit_go && (emit_r == trlls_pkg::EM_SING ||
                               emit_r == trlls_pkg::EM_SUMS))) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      sx_r    <= '0;
      sxx_r   <= '0;
      sy1_r   <= '0;
      sxy1_r  <= '0;
      sy2_r   <= '0;
      sxy2_r  <= '0;
    end else if (accept) begin
      if (has_room) begin
        count_r <= count_r + CW'(1);
        sx_r    <= sx_r + trlls_pkg::SUM_W'(in_predictor);
        sy1_r   <= sy1_r + trlls_pkg::SUM_W'(in_response_one);
        sy2_r   <= sy2_r + trlls_pkg::SUM_W'(in_response_two);
        sxx_r   <= sxx_r + trlls_pkg::PSUM_W'(p_xx);
        sxy1_r  <= sxy1_r + trlls_pkg::PSUM_W'(p_xy1);
        sxy2_r  <= sxy2_r + trlls_pkg::PSUM_W'(p_xy2);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      case (step_r)
        trlls_pkg::ST_NSXX, trlls_pkg::ST_R0_P, trlls_pkg::ST_R1_P: t0_r <= pv;
        trlls_pkg::ST_SXSX:   det_r <= diff[47:0];
        trlls_pkg::ST_R0_Q, trlls_pkg::ST_R1_Q: num_r <= diff;
        trlls_pkg::ST_R0_DIV: begin
          if (resp_r) c0b_r <= dq;
          else c0a_r <= dq;
        end
        trlls_pkg::ST_R1_DIV: begin
          if (resp_r) c1b_r <= dq;
          else c1a_r <= dq;
        end
        trlls_pkg::ST_FIT1: begin
          f1_r <= fit;
          r1_r <= trlls_pkg::sat_sub(y1q, fit);
        end
        trlls_pkg::ST_FIT2: begin
          f2_r <= fit;
          r2_r <= trlls_pkg::sat_sub(y2q, fit);
        end
        default: begin
          acc_r[acc_idx] <= trlls_pkg::sat_add(acc_r[acc_idx], mq);
        end
      endcase
    end else if (emit_go && emit_r == trlls_pkg::EM_COEF) begin
      for (int k = 0; k < 6; k++) acc_r[k] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      case (emit_r)
        trlls_pkg::EM_SING: begin
          out_kind_r   <= trlls_pkg::KIND_COEF;
          out_status_r <= trlls_pkg::STATUS_SINGULAR;
          out_a_r      <= '0;
          out_b_r      <= '0;
          out_c_r      <= '0;
          out_d_r      <= '0;
          out_e_r      <= '0;
          out_f_r      <= '0;
          out_end_r    <= 1'b1;
        end
        trlls_pkg::EM_COEF: begin
          out_kind_r   <= trlls_pkg::KIND_COEF;
          out_status_r <= run_status;
          out_a_r      <= c0a_r;
          out_b_r      <= c1a_r;
          out_c_r      <= c0b_r;
          out_d_r      <= c1b_r;
          out_e_r      <= '0;
          out_f_r      <= '0;
          out_end_r    <= 1'b0;
        end
        trlls_pkg::EM_ROW: begin
          out_kind_r   <= trlls_pkg::KIND_ROW;
          out_status_r <= run_status;
          out_a_r      <= f1_r;
          out_b_r      <= f2_r;
          out_c_r      <= r1_r;
          out_d_r      <= r2_r;
          out_e_r      <= '0;
          out_f_r      <= '0;
          out_end_r    <= 1'b0;
        end
        default: begin
          out_kind_r   <= trlls_pkg::KIND_SUMS;
          out_status_r <= run_status;
          out_a_r      <= acc_r[0];
          out_b_r      <= acc_r[1];
          out_c_r      <= acc_r[2];
          out_d_r      <= acc_r[3];
          out_e_r      <= acc_r[4];
          out_f_r      <= acc_r[5];
          out_end_r    <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_status  = out_status_r;
  assign out_word_a  = out_a_r;
  assign out_word_b  = out_b_r;
  assign out_word_c  = out_c_r;
  assign out_word_d  = out_d_r;
  assign out_word_e  = out_e_r;
  assign out_word_f  = out_f_r;
  assign out_run_end = out_end_r;

endmodule

FILE: rtl/core/two_response_linear_least_squares.sv
// ----------------------------------------------------------------------------
// two_response_linear_least_squares
// Least-squares line fit of two responses against one predictor, with
// per-sample fitted values, residuals and cross-product sums.
//
//   Port group | Direction | Handshake            | Word
//   in_*       | input     | in_valid / in_ready  | one Q7.8 sample
//   out_*      | output    | out_valid / out_ready| one Q31.16 result
//
// A sample is accepted whenever in_valid and in_ready are both high. After
// the final sample the solve runs, then each stored sample is replayed;
// both run on the shared 48-step multiply and 80-step divide unit.
// in_ready is low from the final sample until the last result is loaded.
// Reset clears the sample count and sums; the sample RAM is not cleared.
// A stalled out_ready holds the result register and pauses the sequencer.
// ----------------------------------------------------------------------------
module two_response_linear_least_squares #(
  parameter int MAX_SAMPLES = trlls_pkg::MAX_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_predictor,
  input  logic signed [15:0] in_response_one,
  input  logic signed [15:0] in_response_two,
  input  logic               in_final_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [1:0]         out_status,
  output logic signed [47:0] out_word_a,
  output logic signed [47:0] out_word_b,
  output logic signed [47:0] out_word_c,
  output logic signed [47:0] out_word_d,
  output logic signed [47:0] out_word_e,
  output logic signed [47:0] out_word_f,
  output logic               out_run_end
);

  localparam int AW = $clog2(MAX_SAMPLES);

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [47:0]        ram_wdata, ram_rdata;
  trlls_pkg::au_req_t au_req;
  trlls_pkg::au_rsp_t au_rsp;

  trlls_ram #(
    .WIDTH (48),
    .DEPTH (MAX_SAMPLES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  trlls_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (au_req),
    .rsp   (au_rsp)
  );

  trlls_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .AW          (AW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_predictor    (in_predictor),
    .in_response_one (in_response_one),
    .in_response_two (in_response_two),
    .in_final_sample (in_final_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_status      (out_status),
    .out_word_a      (out_word_a),
    .out_word_b      (out_word_b),
    .out_word_c      (out_word_c),
    .out_word_d      (out_word_d),
    .out_word_e      (out_word_e),
    .out_word_f      (out_word_f),
    .out_run_end     (out_run_end),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .au_req          (au_req),
    .au_rsp          (au_rsp)
  );

endmodule

FILE: rtl/core/trlls_checker.sv
// ----------------------------------------------------------------------------
// trlls_checker
// Port-level checks on the result channel of the least-squares fitter.
// ----------------------------------------------------------------------------
module trlls_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_kind,
  input logic [1:0]         out_status,
  input logic signed [47:0] out_word_a,
  input logic signed [47:0] out_word_e,
  input logic signed [47:0] out_word_f,
  input logic               out_run_end
);

  // A stalled word keeps its first data word.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word_a))
    else $error("result word changed while stalled");

  // Only a coefficient or sums word can close a run.
  a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_end |-> out_kind != trlls_pkg::KIND_ROW)
    else $error("run closed by a per-sample row");

  // A singular fit is a single closing coefficient word of zeros.
  a_singular: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == trlls_pkg::STATUS_SINGULAR |->
      out_run_end && out_kind == trlls_pkg::KIND_COEF && out_word_a == 48'sd0)
    else $error("malformed singular result");

  a_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == trlls_pkg::KIND_ROW |->
      out_word_e == 48'sd0 && out_word_f == 48'sd0)
    else $error("row word carries nonzero tail fields");

endmodule

bind two_response_linear_least_squares trlls_checker u_trlls_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_kind    (out_kind),
  .out_status  (out_status),
  .out_word_a  (out_word_a),
  .out_word_e  (out_word_e),
  .out_word_f  (out_word_f),
  .out_run_end (out_run_end)
);
